// File: design/fmau_pkg.sv
// Shared types, constants and helper functions of the fused multiply-add unit.
// Every pipeline module imports this package; it depends on nothing else.
package fmau_pkg;

    localparam int EXP_W  = 14;
    localparam int MAN_W  = 53;
    localparam int PROD_W = 106;
    localparam int WIDE_W = 128;

    typedef logic signed [EXP_W-1:0] t_exp;

    typedef enum logic [1:0] {
        ORD_132,
        ORD_213,
        ORD_231
    } t_order;

    typedef struct packed {
        logic   bad;
        logic   neg_prod;
        logic   neg_add;
        t_order order;
    } t_variant;

    // Variant decode: operand order is code mod 3, the negations come from code div 3.
    localparam t_variant VARIANT_TABLE [16] = '{
        '{1'b0, 1'b0, 1'b0, ORD_132}, '{1'b0, 1'b0, 1'b0, ORD_213},
        '{1'b0, 1'b0, 1'b0, ORD_231}, '{1'b0, 1'b0, 1'b1, ORD_132},
        '{1'b0, 1'b0, 1'b1, ORD_213}, '{1'b0, 1'b0, 1'b1, ORD_231},
        '{1'b0, 1'b1, 1'b0, ORD_132}, '{1'b0, 1'b1, 1'b0, ORD_213},
        '{1'b0, 1'b1, 1'b0, ORD_231}, '{1'b0, 1'b1, 1'b1, ORD_132},
        '{1'b0, 1'b1, 1'b1, ORD_213}, '{1'b0, 1'b1, 1'b1, ORD_231},
        '{1'b1, 1'b0, 1'b0, ORD_231}, '{1'b1, 1'b0, 1'b0, ORD_231},
        '{1'b1, 1'b0, 1'b0, ORD_231}, '{1'b1, 1'b0, 1'b0, ORD_231}
    };

    typedef struct packed {
        logic [3:0]  req_type;
        logic        double_precision;
        logic [63:0] src_one;
        logic [63:0] src_two;
        logic [63:0] old_dest;
    } t_req;

    typedef struct packed {
        logic [63:0] sum_bits;
        logic        bad_variant;
    } t_rsp;

    typedef struct packed {
        logic             sign;
        t_exp             exp;
        logic [MAN_W-1:0] man;
    } t_opnd;

    typedef struct packed {
        logic        special;
        logic [63:0] value;
    } t_special;

    typedef struct packed {
        logic     dp;
        logic     bad;
        t_special spec;
        logic     ps;
        logic     c_zero;
        t_opnd    m1;
        t_opnd    m2;
        t_opnd    ad;
    } t_unp;

    typedef struct packed {
        logic              dp;
        logic              bad;
        t_special          spec;
        logic              ps;
        logic              c_zero;
        t_exp              ep;
        logic [PROD_W-1:0] pm;
        t_opnd             ad;
    } t_prod;

    typedef struct packed {
        logic              dp;
        logic              bad;
        t_special          spec;
        logic              sign;
        t_exp              lsb_exp;
        logic [WIDE_W-1:0] mag;
    } t_sum;

    // Right shift that ORs every bit shifted out into the least significant bit.
    function automatic logic [WIDE_W-1:0] shr_jam(input logic [WIDE_W-1:0] x,
                                                  input logic [EXP_W-1:0]  amt);
        logic [WIDE_W-1:0] r;
        logic [WIDE_W-1:0] mask;
        r    = '0;
        mask = '0;
        if (amt >= EXP_W'(WIDE_W)) begin
            r[0] = |x;
        end else begin
            r    = x >> amt;
            mask = ~({WIDE_W{1'b1}} << amt);
            r[0] = r[0] | (|(x & mask));
        end
        return r;
    endfunction

endpackage

// File: design/fmau_unpack.sv
// Operand selection, classification, special-case results and operand normalisation.
// Two pipeline stages; depends on fmau_pkg.
module fmau_unpack import fmau_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_req i_data,
    output logic o_ready,
    output logic o_valid,
    output t_unp o_data,
    input  logic i_ready
);

    typedef struct packed {
        logic  nan;
        logic  inf;
        logic  zer;
        t_opnd op;
    } t_class;

    localparam t_exp DP_OFS = 14'sd1075;
    localparam t_exp SP_OFS = 14'sd179;

    function automatic t_class classify(input logic [63:0] x, input logic dp);
        t_class      c;
        logic [10:0] ex;
        logic [51:0] fr;
        logic        ex_max;
        logic        ex_zero;
        logic        fr_zero;
        t_exp        e_eff;
        if (dp) begin
            ex        = x[62:52];
            fr        = x[51:0];
            ex_max    = &x[62:52];
            c.op.sign = x[63];
        end else begin
            ex        = {3'b0, x[30:23]};
            fr        = {x[22:0], 29'b0};
            ex_max    = &x[30:23];
            c.op.sign = x[31];
        end
        ex_zero  = (ex == '0);
        fr_zero  = (fr == '0);
        c.nan    = ex_max & ~fr_zero;
        c.inf    = ex_max & fr_zero;
        c.zer    = ex_zero & fr_zero;
        c.op.man = {~ex_zero, fr};
        e_eff    = ex_zero ? 14'sd1 : $signed({3'b0, ex});
        c.op.exp = e_eff - (dp ? DP_OFS : SP_OFS);
        return c;
    endfunction

    function automatic logic [5:0] lzc53(input logic [MAN_W-1:0] x);
        logic [5:0] n;
        n = 6'(MAN_W);
        for (int i = 0; i < MAN_W; i++) begin
            if (x[i]) n = 6'(MAN_W - 1 - i);
        end
        return n;
    endfunction

    function automatic t_opnd normalise(input t_opnd x);
        t_opnd      r;
        logic [5:0] lz;
        lz    = lzc53(x.man);
        r     = x;
        r.man = x.man << lz;
        r.exp = x.exp - $signed({8'b0, lz});
        return r;
    endfunction

    logic   r_a_v, r_b_v;
    t_unp   r_a, r_b;
    t_unp   n_a, n_b;
    logic   en_a, en_b;

    logic [63:0] mask, opa, opb, opc, m1, m2, ad, m1n, adn, sbit, qbit, dnan, infv, zerv;
    t_variant    vt;
    t_class      c1, c2, c3;
    logic        ps, pinf, pzero, dp;

    assign en_b    = !r_b_v || i_ready;
    assign en_a    = !r_a_v || en_b;
    assign o_ready = en_a;
    assign o_valid = r_b_v;
    assign o_data  = r_b;

    always_comb begin
        dp   = i_data.double_precision;
        vt   = VARIANT_TABLE[i_data.req_type];
        mask = dp ? 64'hFFFF_FFFF_FFFF_FFFF : 64'h0000_0000_FFFF_FFFF;
        opa  = i_data.src_one & mask;
        opb  = i_data.src_two & mask;
        opc  = i_data.old_dest & mask;
        case (vt.order)
            ORD_132: begin
                m1 = opc; m2 = opb; ad = opa;
            end
            ORD_213: begin
                m1 = opa; m2 = opc; ad = opb;
            end
            default: begin
                m1 = opa; m2 = opb; ad = opc;
            end
        endcase
        sbit = dp ? 64'h8000_0000_0000_0000 : 64'h0000_0000_8000_0000;
        qbit = dp ? 64'h0008_0000_0000_0000 : 64'h0000_0000_0040_0000;
        m1n  = vt.neg_prod ? (m1 ^ sbit) : m1;
        adn  = vt.neg_add ? (ad ^ sbit) : ad;
        c1   = classify(m1n, dp);
        c2   = classify(m2, dp);
        c3   = classify(adn, dp);
        ps    = c1.op.sign ^ c2.op.sign;
        pinf  = c1.inf | c2.inf;
        pzero = c1.zer | c2.zer;
        dnan = dp ? 64'hFFF8_0000_0000_0000 : 64'h0000_0000_FFC0_0000;
        infv = dp ? {ps, 11'h7FF, 52'b0} : {32'b0, ps, 8'hFF, 23'b0};
        zerv = dp ? {ps & c3.op.sign, 63'b0} : {32'b0, ps & c3.op.sign, 31'b0};

        n_a.dp           = dp;
        n_a.bad          = vt.bad;
        n_a.ps           = ps;
        n_a.c_zero       = c3.zer;
        n_a.m1           = c1.op;
        n_a.m2           = c2.op;
        n_a.ad           = c3.op;
        n_a.spec.special = 1'b1;
        if (vt.bad) begin
            n_a.spec.value = '0;
        end else if (c1.nan) begin
            n_a.spec.value = m1n | qbit;
        end else if (c2.nan) begin
            n_a.spec.value = m2 | qbit;
        end else if (c3.nan) begin
            n_a.spec.value = adn | qbit;
        end else if (pinf && pzero) begin
            n_a.spec.value = dnan;
        end else if (pinf) begin
            n_a.spec.value = (c3.inf && (c3.op.sign != ps)) ? dnan : infv;
        end else if (c3.inf) begin
            n_a.spec.value = adn;
        end else if (pzero) begin
            n_a.spec.value = c3.zer ? zerv : adn;
        end else begin
            n_a.spec.special = 1'b0;
            n_a.spec.value   = '0;
        end
    end

    always_comb begin
        n_b    = r_a;
        n_b.m1 = normalise(r_a.m1);
        n_b.m2 = normalise(r_a.m2);
        n_b.ad = normalise(r_a.ad);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
        end else begin
            if (en_a) r_a_v <= i_valid;
            if (en_b) r_b_v <= r_a_v;
        end
        if (en_a) r_a <= n_a;
        if (en_b) r_b <= n_b;
    end

endmodule

// File: design/fmau_mul.sv
// Significand multiplier: four partial products, then their sum.
// Two pipeline stages; depends on fmau_pkg.
module fmau_mul import fmau_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_unp  i_data,
    output logic  o_ready,
    output logic  o_valid,
    output t_prod o_data,
    input  logic  i_ready
);

    typedef struct packed {
        logic        dp;
        logic        bad;
        t_special    spec;
        logic        ps;
        logic        c_zero;
        t_exp        ep;
        logic [63:0] p00;
        logic [52:0] p01;
        logic [52:0] p10;
        logic [41:0] p11;
        t_opnd       ad;
    } t_pp;

    logic  r_c_v, r_d_v;
    t_pp   r_c, n_c;
    t_prod r_d, n_d;
    logic  en_c, en_d;

    logic [31:0] a0, b0;
    logic [20:0] a1, b1;

    assign en_d    = !r_d_v || i_ready;
    assign en_c    = !r_c_v || en_d;
    assign o_ready = en_c;
    assign o_valid = r_d_v;
    assign o_data  = r_d;

    always_comb begin
        a0         = i_data.m1.man[31:0];
        a1         = i_data.m1.man[52:32];
        b0         = i_data.m2.man[31:0];
        b1         = i_data.m2.man[52:32];
        n_c.dp     = i_data.dp;
        n_c.bad    = i_data.bad;
        n_c.spec   = i_data.spec;
        n_c.ps     = i_data.ps;
        n_c.c_zero = i_data.c_zero;
        n_c.ep     = i_data.m1.exp + i_data.m2.exp;
        n_c.p00    = a0 * b0;
        n_c.p01    = a0 * b1;
        n_c.p10    = a1 * b0;
        n_c.p11    = a1 * b1;
        n_c.ad     = i_data.ad;
    end

    always_comb begin
        n_d.dp     = r_c.dp;
        n_d.bad    = r_c.bad;
        n_d.spec   = r_c.spec;
        n_d.ps     = r_c.ps;
        n_d.c_zero = r_c.c_zero;
        n_d.ep     = r_c.ep;
        n_d.ad     = r_c.ad;
        n_d.pm     = PROD_W'(r_c.p00)
                   + (PROD_W'(r_c.p01) << 32)
                   + (PROD_W'(r_c.p10) << 32)
                   + (PROD_W'(r_c.p11) << 64);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_v <= 1'b0;
            r_d_v <= 1'b0;
        end else begin
            if (en_c) r_c_v <= i_valid;
            if (en_d) r_d_v <= r_c_v;
        end
        if (en_c) r_c <= n_c;
        if (en_d) r_d <= n_d;
    end

endmodule

// File: design/fmau_align_add.sv
// Alignment of product and addend in a 128-bit window, then add or subtract.
// Two pipeline stages; depends on fmau_pkg.
module fmau_align_add import fmau_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_prod i_data,
    output logic  o_ready,
    output logic  o_valid,
    output t_sum  o_data,
    input  logic  i_ready
);

    typedef struct packed {
        logic              dp;
        logic              bad;
        t_special          spec;
        logic              ps;
        logic              sc;
        t_exp              lsb_exp;
        logic [WIDE_W-1:0] px;
        logic [WIDE_W-1:0] cx;
    } t_al;

    logic r_e_v, r_f_v;
    t_al  r_e, n_e;
    t_sum r_f, n_f;
    logic en_e, en_f;

    logic [WIDE_W-1:0] px, cx, sh_in, sh_out;
    logic [EXP_W-1:0]  amt;
    t_exp              tp, tc, d;
    logic              d_neg;
    logic [WIDE_W:0]   diff;

    assign en_f    = !r_f_v || i_ready;
    assign en_e    = !r_e_v || en_f;
    assign o_ready = en_e;
    assign o_valid = r_f_v;
    assign o_data  = r_f;

    // The product sits with its leading one at bit 125 or 126, the addend at bit 126,
    // so an addition never carries out of the window.
    always_comb begin
        px     = {1'b0, i_data.pm, 21'b0};
        cx     = {1'b0, i_data.ad.man, 74'b0};
        tp     = i_data.ep - 14'sd21;
        tc     = i_data.ad.exp - 14'sd74;
        d      = tp - tc;
        d_neg  = d[EXP_W-1];
        sh_in  = d_neg ? px : cx;
        amt    = d_neg ? EXP_W'(-d) : EXP_W'(d);
        sh_out = shr_jam(sh_in, amt);

        n_e.dp   = i_data.dp;
        n_e.bad  = i_data.bad;
        n_e.spec = i_data.spec;
        n_e.ps   = i_data.ps;
        n_e.sc   = i_data.ad.sign;
        if (i_data.c_zero) begin
            n_e.px      = px;
            n_e.cx      = '0;
            n_e.lsb_exp = tp;
        end else if (d_neg) begin
            n_e.px      = sh_out;
            n_e.cx      = cx;
            n_e.lsb_exp = tc;
        end else begin
            n_e.px      = px;
            n_e.cx      = sh_out;
            n_e.lsb_exp = tp;
        end
    end

    always_comb begin
        diff        = {1'b0, r_e.px} - {1'b0, r_e.cx};
        n_f.dp      = r_e.dp;
        n_f.bad     = r_e.bad;
        n_f.spec    = r_e.spec;
        n_f.lsb_exp = r_e.lsb_exp;
        if (r_e.ps == r_e.sc) begin
            n_f.mag  = r_e.px + r_e.cx;
            n_f.sign = r_e.ps;
        end else if (diff[WIDE_W]) begin
            n_f.mag  = ~diff[WIDE_W-1:0] + WIDE_W'(1);
            n_f.sign = r_e.sc;
        end else begin
            n_f.mag  = diff[WIDE_W-1:0];
            n_f.sign = r_e.ps;
        end
        // Exact cancellation of nonzero values gives positive zero.
        if (!r_e.spec.special && (n_f.mag == '0)) begin
            n_f.spec.special = 1'b1;
            n_f.spec.value   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_v <= 1'b0;
            r_f_v <= 1'b0;
        end else begin
            if (en_e) r_e_v <= i_valid;
            if (en_f) r_f_v <= r_e_v;
        end
        if (en_e) r_e <= n_e;
        if (en_f) r_f <= n_f;
    end

endmodule

// File: design/fmau_round.sv
// Normalisation, subnormal shift, round-to-nearest-even and packing of the result.
// Four pipeline stages, the last being the output register; depends on fmau_pkg.
module fmau_round import fmau_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_sum i_data,
    output logic o_ready,
    output logic o_valid,
    output t_rsp o_data,
    input  logic i_ready
);

    typedef struct packed {
        t_sum       s;
        logic [6:0] lz;
    } t_lz;

    typedef struct packed {
        logic              dp;
        logic              bad;
        t_special          spec;
        logic              sign;
        t_exp              lead_exp;
        logic [WIDE_W-1:0] mag;
        logic [6:0]        amt;
    } t_nrm;

    function automatic logic [6:0] lzc128(input logic [WIDE_W-1:0] x);
        logic [6:0] n;
        n = 7'(WIDE_W - 1);
        for (int i = 0; i < WIDE_W; i++) begin
            if (x[i]) n = 7'(WIDE_W - 1 - i);
        end
        return n;
    endfunction

    logic r_g_v, r_h_v, r_i_v, r_out_v;
    t_lz  r_g, n_g;
    t_nrm r_h, n_h, r_i, n_i;
    t_rsp r_out, n_out;
    logic en_g, en_h, en_i, en_out;

    t_exp        lead, emin, dsh, bias, emax, be, lead_r;
    logic        denorm;
    logic [52:0] mant;
    logic [53:0] mr;
    logic        guard, sticky, inc, carry, hid;
    logic [63:0] packed_bits;

    assign en_out  = !r_out_v || i_ready;
    assign en_i    = !r_i_v || en_out;
    assign en_h    = !r_h_v || en_i;
    assign en_g    = !r_g_v || en_h;
    assign o_ready = en_g;
    assign o_valid = r_out_v;
    assign o_data  = r_out;

    always_comb begin
        n_g.s  = i_data;
        n_g.lz = lzc128(i_data.mag);
    end

    // After the left shift the leading one sits at bit 127; results below the normal
    // range are shifted right again so that their exponent becomes the minimum one.
    always_comb begin
        lead   = r_g.s.lsb_exp - $signed({7'b0, r_g.lz}) + 14'sd127;
        emin   = r_g.s.dp ? -14'sd1022 : -14'sd126;
        dsh    = emin - lead;
        denorm = !dsh[EXP_W-1] && (dsh != '0);
        n_h.dp       = r_g.s.dp;
        n_h.bad      = r_g.s.bad;
        n_h.spec     = r_g.s.spec;
        n_h.sign     = r_g.s.sign;
        n_h.mag      = r_g.s.mag << r_g.lz;
        n_h.lead_exp = denorm ? emin : lead;
        if (!denorm) begin
            n_h.amt = '0;
        end else if (dsh > 14'sd127) begin
            n_h.amt = 7'd127;
        end else begin
            n_h.amt = dsh[6:0];
        end
    end

    always_comb begin
        n_i     = r_h;
        n_i.mag = shr_jam(r_h.mag, EXP_W'(r_h.amt));
    end

    always_comb begin
        if (r_i.dp) begin
            mant   = r_i.mag[127:75];
            guard  = r_i.mag[74];
            sticky = |r_i.mag[73:0];
            bias   = 14'sd1023;
            emax   = 14'sd2047;
        end else begin
            mant   = {29'b0, r_i.mag[127:104]};
            guard  = r_i.mag[103];
            sticky = |r_i.mag[102:0];
            bias   = 14'sd127;
            emax   = 14'sd255;
        end
        inc    = guard & (sticky | mant[0]);
        mr     = {1'b0, mant} + {53'b0, inc};
        carry  = r_i.dp ? mr[53] : mr[24];
        lead_r = r_i.lead_exp;
        if (carry) begin
            mr     = mr >> 1;
            lead_r = r_i.lead_exp + 14'sd1;
        end
        hid = r_i.dp ? mr[52] : mr[23];
        be  = lead_r + bias;
        if (!hid) begin
            packed_bits = r_i.dp ? {r_i.sign, 11'b0, mr[51:0]}
                                 : {32'b0, r_i.sign, 8'b0, mr[22:0]};
        end else if (be >= emax) begin
            packed_bits = r_i.dp ? {r_i.sign, 11'h7FF, 52'b0}
                                 : {32'b0, r_i.sign, 8'hFF, 23'b0};
        end else begin
            packed_bits = r_i.dp ? {r_i.sign, be[10:0], mr[51:0]}
                                 : {32'b0, r_i.sign, be[7:0], mr[22:0]};
        end
        n_out.sum_bits    = r_i.spec.special ? r_i.spec.value : packed_bits;
        n_out.bad_variant = r_i.bad;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_v   <= 1'b0;
            r_h_v   <= 1'b0;
            r_i_v   <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (en_g)   r_g_v   <= i_valid;
            if (en_h)   r_h_v   <= r_g_v;
            if (en_i)   r_i_v   <= r_h_v;
            if (en_out) r_out_v <= r_i_v;
        end
        if (en_g)   r_g   <= n_g;
        if (en_h)   r_h   <= n_h;
        if (en_i)   r_i   <= n_i;
        if (en_out) r_out <= n_out;
    end

endmodule

// File: design/fused_multiply_add_unit.sv
// Fused multiply-add unit, top level: a ten-stage pipeline that accepts one transaction
// per clock cycle while the output side does not stall. The rate of one transaction per
// cycle is set by the pipeline itself: every stage holds one item, and the 53 by 53 bit
// significand product is split into four partial products of at most 32 by 32 bits in one
// stage and summed in the next. A stall on the output holds the result register; stages
// behind it keep filling any empty slots, so the input stalls only once the whole
// pipeline is full.
// Depends on fmau_pkg and the four pipeline modules.
module fused_multiply_add_unit import fmau_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_req i_data,
    output logic o_stall,
    output logic o_valid,
    output t_rsp o_data,
    input  logic i_stall
);

    // Stage map: operand selection and classification, operand normalisation,
    // partial products, product sum, alignment, add or subtract, leading-zero count,
    // normalising shift, subnormal shift, and finally rounding into the output register.
    // Special operands (NaN, infinity, a zero factor, an unknown variant) are resolved in the
    // first stage and ride down the pipeline beside the datapath.

    logic  up_ready, mul_ready, aa_ready, rnd_ready;
    logic  unp_valid, mul_valid, aa_valid;
    t_unp  unp_data;
    t_prod mul_data;
    t_sum  aa_data;

    assign o_stall = !up_ready;

    fmau_unpack u_unpack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_data  (i_data),
        .o_ready (up_ready),
        .o_valid (unp_valid),
        .o_data  (unp_data),
        .i_ready (mul_ready)
    );

    fmau_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (unp_valid),
        .i_data  (unp_data),
        .o_ready (mul_ready),
        .o_valid (mul_valid),
        .o_data  (mul_data),
        .i_ready (aa_ready)
    );

    fmau_align_add u_align_add (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (mul_valid),
        .i_data  (mul_data),
        .o_ready (aa_ready),
        .o_valid (aa_valid),
        .o_data  (aa_data),
        .i_ready (rnd_ready)
    );

    // The final stage's ready is simply the absence of an output stall.
    fmau_round u_round (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (aa_valid),
        .i_data  (aa_data),
        .o_ready (rnd_ready),
        .o_valid (o_valid),
        .o_data  (o_data),
        .i_ready (!i_stall)
    );

endmodule

// File: test/fma_result_checker.sv
// Result checker for the fused multiply-add unit: watches both channels, predicts every
// result in IEEE binary32/binary64 arithmetic and compares it with what the unit returns.
// Depends on fmau_pkg for the transaction types and the operand order codes.
module fma_result_checker import fmau_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    input  logic i_req_stall,
    input  t_req i_req,
    input  logic i_rsp_valid,
    input  logic i_rsp_stall,
    input  t_rsp i_rsp,
    output int   o_mismatches,
    output int   o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LAST_VALID_VARIANT = 11;
    localparam int Q_NEG_ADD  = 1;
    localparam int Q_NEG_PROD = 2;

    t_rsp expected_sums[$];
    int   mismatches = 0;

    assign o_mismatches  = mismatches;
    assign o_outstanding = expected_sums.size();

    function automatic int bit_length(input logic [127:0] x);
        for (int i = 127; i >= 0; i--) begin
            if (x[i]) return i + 1;
        end
        return 0;
    endfunction

    function automatic logic [127:0] shift_right_sticky(input logic [127:0] x, input int n);
        logic [127:0] r;
        logic [127:0] msk;
        if (n <= 0) return x;
        if (n >= 128) return {127'd0, |x};
        r   = x >> n;
        msk = ~({128{1'b1}} << n);
        r[0] = r[0] | (|(x & msk));
        return r;
    endfunction

    // Rounds sign * r * 2^t to nearest even in a format with fb fraction and eb exponent bits.
    function automatic logic [63:0] round_to_format(input logic sgn, input logic [127:0] r,
                                                    input int t, input int fb, input int eb);
        int bias, emax, sp, s, smin, be;
        logic [63:0]  mant;
        logic [127:0] sh;
        logic [127:0] msk;
        logic         guard, sticky;
        logic [63:0]  sword;
        bias  = (1 << (eb - 1)) - 1;
        emax  = (1 << eb) - 1;
        sp    = fb + eb;
        sword = 64'(sgn) << sp;
        s     = bit_length(r) - 1 - fb;
        smin  = 1 - bias - fb - t;
        if (s < smin) s = smin;
        if (s <= 0) begin
            sh   = (-s >= 128) ? '0 : (r << (-s));
            mant = sh[63:0];
        end else begin
            sh     = (s >= 128) ? '0 : (r >> s);
            mant   = sh[63:0];
            guard  = (s - 1 < 128) ? r[s-1] : 1'b0;
            msk    = (s - 1 >= 128) ? {128{1'b1}} : ~({128{1'b1}} << (s - 1));
            sticky = |(r & msk);
            if (guard && (sticky || mant[0])) mant++;
        end
        if ((mant >> (fb + 1)) != 0) begin
            mant = mant >> 1;
            s++;
        end
        if (mant >= (64'd1 << fb)) begin
            be = t + s + fb + bias;
            if (be >= emax) return sword | (64'(emax) << fb);
            return sword | (64'(be) << fb) | (mant & ((64'd1 << fb) - 1));
        end
        return sword | mant;
    endfunction

    // Single-rounded x * y + z on raw operand bits.
    function automatic logic [63:0] fused_mul_add(input logic [63:0] x, input logic [63:0] y,
                                                  input logic [63:0] z, input int fb,
                                                  input int eb);
        int bias, sp, lp, tp, lc, tc, tmax;
        logic [63:0] emax, fmask, qbit, dnan, ps, sgn_r;
        logic [63:0] op [3];
        logic [63:0] sg [3];
        logic [63:0] ex [3];
        logic [63:0] fr [3];
        logic [63:0] m  [3];
        int          e  [3];
        logic        is_nan [3];
        logic        is_inf [3];
        logic        is_zero [3];
        logic        pinf, pzero;
        logic [127:0] p, px, cx, r;
        bias  = (1 << (eb - 1)) - 1;
        emax  = (64'd1 << eb) - 1;
        sp    = fb + eb;
        fmask = (64'd1 << fb) - 1;
        qbit  = 64'd1 << (fb - 1);
        dnan  = (64'd1 << sp) | (emax << fb) | qbit;
        op[0] = x;
        op[1] = y;
        op[2] = z;
        for (int i = 0; i < 3; i++) begin
            sg[i] = (op[i] >> sp) & 1;
            ex[i] = (op[i] >> fb) & emax;
            fr[i] = op[i] & fmask;
            is_nan[i]  = ex[i] == emax && fr[i] != 0;
            is_inf[i]  = ex[i] == emax && fr[i] == 0;
            is_zero[i] = ex[i] == 0 && fr[i] == 0;
        end
        for (int i = 0; i < 3; i++) begin
            if (is_nan[i]) return op[i] | qbit;
        end
        ps    = sg[0] ^ sg[1];
        pinf  = is_inf[0] || is_inf[1];
        pzero = is_zero[0] || is_zero[1];
        if (pinf && pzero) return dnan;
        if (pinf) begin
            if (is_inf[2] && sg[2] != ps) return dnan;
            return (ps << sp) | (emax << fb);
        end
        if (is_inf[2]) return z;
        if (pzero) begin
            if (is_zero[2]) return (ps & sg[2]) << sp;
            return z;
        end
        for (int i = 0; i < 3; i++) begin
            e[i] = (ex[i] != 0) ? int'(ex[i]) : 1;
            m[i] = fr[i] | ((ex[i] != 0) ? (64'd1 << fb) : 64'd0);
        end
        p  = 128'(m[0]) * 128'(m[1]);
        lp = bit_length(p);
        tp = e[0] + e[1] - 2 * bias - 2 * fb + lp - 1;
        px = p << (127 - lp);
        if (is_zero[2]) return round_to_format(ps[0], px, tp - 126, fb, eb);
        lc = bit_length(128'(m[2]));
        tc = e[2] - bias - fb + lc - 1;
        cx = 128'(m[2]) << (127 - lc);
        if (tp >= tc) begin
            cx   = shift_right_sticky(cx, tp - tc);
            tmax = tp;
        end else begin
            px   = shift_right_sticky(px, tc - tp);
            tmax = tc;
        end
        if (ps == sg[2]) begin
            r     = px + cx;
            sgn_r = ps;
        end else if (px == cx) begin
            return 64'd0;
        end else if (px > cx) begin
            r     = px - cx;
            sgn_r = ps;
        end else begin
            r     = cx - px;
            sgn_r = sg[2];
        end
        return round_to_format(sgn_r[0], r, tmax - 126, fb, eb);
    endfunction

    function automatic t_rsp predict_sum(input t_req req);
        t_rsp        rsp;
        logic [63:0] msk, a, b, c, m1, m2, ad, sbit;
        t_order      ord;
        int          q;
        rsp = '0;
        if (int'(req.req_type) > LAST_VALID_VARIANT) begin
            rsp.bad_variant = 1'b1;
            return rsp;
        end
        msk = req.double_precision ? {64{1'b1}} : 64'h0000_0000_FFFF_FFFF;
        a   = req.src_one & msk;
        b   = req.src_two & msk;
        c   = req.old_dest & msk;
        ord = t_order'(req.req_type % 3);
        q   = req.req_type / 3;
        case (ord)
            ORD_132: begin m1 = c; m2 = b; ad = a; end
            ORD_213: begin m1 = a; m2 = c; ad = b; end
            default: begin m1 = a; m2 = b; ad = c; end
        endcase
        sbit = req.double_precision ? (64'd1 << 63) : (64'd1 << 31);
        if (q & Q_NEG_PROD) m1 = m1 ^ sbit;
        if (q & Q_NEG_ADD)  ad = ad ^ sbit;
        if (req.double_precision) rsp.sum_bits = fused_mul_add(m1, m2, ad, 52, 11);
        else rsp.sum_bits = fused_mul_add(m1, m2, ad, 23, 8) & msk;
        return rsp;
    endfunction

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t: %s differs: got %h, expected %h", $time, field, got, want);
        mismatches++;
    endtask

    // Inputs are taken before outputs so a transaction accepted at this edge is queued first.
    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n) begin
            if (i_req_valid && !i_req_stall) expected_sums.push_back(predict_sum(i_req));
            if (i_rsp_valid && !i_rsp_stall) begin
                if (expected_sums.size() == 0) begin
                    report_mismatch("unexpected result", i_rsp.sum_bits, 64'd0);
                end else begin
                    want = expected_sums.pop_front();
                    if (i_rsp.sum_bits !== want.sum_bits)
                        report_mismatch("sum_bits", i_rsp.sum_bits, want.sum_bits);
                    if (i_rsp.bad_variant !== want.bad_variant)
                        report_mismatch("bad_variant", 64'(i_rsp.bad_variant),
                                        64'(want.bad_variant));
                end
            end
        end
    end

endmodule

// File: test/tb_fused_multiply_add_unit.sv
// Top of the fused multiply-add unit testbench: clock, reset, stimulus and verdict.
// Depends on fmau_pkg, the unit itself and fma_result_checker, which does all checking.
module tb_fused_multiply_add_unit import fmau_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS  = 730;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int DRAIN_CYCLES  = 40;
    localparam int LONG_HOLD     = 80;
    localparam int HOLD_AT_ITEM  = 200;
    localparam int PAUSE_AT_ITEM = 450;
    localparam logic [3:0] FIRST_BAD_VARIANT = 4'd12;
    localparam logic [3:0] LAST_GOOD_VARIANT = 4'd11;
    localparam logic [3:0] VARIANT_231_ADD   = 4'd2;

    // Frequently used binary64 and binary32 bit patterns.
    localparam logic [63:0] D_ONE   = 64'h3FF0_0000_0000_0000;
    localparam logic [63:0] D_TWO   = 64'h4000_0000_0000_0000;
    localparam logic [63:0] D_THREE = 64'h4008_0000_0000_0000;
    localparam logic [63:0] D_NSIX  = 64'hC018_0000_0000_0000;
    localparam logic [63:0] D_INF   = 64'h7FF0_0000_0000_0000;
    localparam logic [63:0] D_NINF  = 64'hFFF0_0000_0000_0000;
    localparam logic [63:0] D_SNAN  = 64'h7FF0_0000_0000_0001;
    localparam logic [63:0] D_MAX   = 64'h7FEF_FFFF_FFFF_FFFF;
    localparam logic [63:0] D_TINY  = 64'h0000_0000_0000_0001;
    localparam logic [63:0] D_HALF  = 64'h3FE0_0000_0000_0000;
    localparam logic [63:0] D_NZERO = 64'h8000_0000_0000_0000;
    localparam logic [63:0] S_ONE   = 64'hDEAD_BEEF_3F80_0000;
    localparam logic [63:0] S_TWO   = 64'h1234_5678_4000_0000;
    localparam logic [63:0] S_MAX   = 64'hFFFF_FFFF_7F7F_FFFF;
    localparam logic [63:0] S_TINY  = 64'h0000_0000_0000_0001;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    t_req i_data;
    logic o_stall;
    logic o_valid;
    t_rsp o_data;
    logic i_stall;
    int   mismatches;
    int   outstanding;
    int   sent;
    int   cycles;

    fused_multiply_add_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_data  (i_data),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .o_data  (o_data),
        .i_stall (i_stall)
    );

    fma_result_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (i_valid),
        .i_req_stall   (o_stall),
        .i_req         (i_data),
        .i_rsp_valid   (o_valid),
        .i_rsp_stall   (i_stall),
        .i_rsp         (o_data),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // The run is cut short if the unit ever locks up.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // One random operand in the chosen precision. The categories push the arithmetic
    // towards its special cases: signed zeros, infinities, quiet and signalling NaNs,
    // subnormals, the format extremes, short significands with small exponents and values
    // of moderate exponent, where products and addends line up and cancel. For binary32 the
    // upper half is junk that the unit must ignore.
    function automatic logic [63:0] pick_operand(input logic dp);
        int          fb, eb, bias, kind;
        logic [63:0] emax, fmask, sgn, expo, frac, val;
        fb    = dp ? 52 : 23;
        eb    = dp ? 11 : 8;
        bias  = (1 << (eb - 1)) - 1;
        emax  = (64'd1 << eb) - 1;
        fmask = (64'd1 << fb) - 1;
        kind  = $urandom_range(0, 12);
        sgn   = 64'($urandom_range(0, 1));
        frac  = {$urandom, $urandom} & fmask;
        case (kind)
            0: begin expo = 0; frac = 0; end
            1: begin expo = emax; frac = 0; end
            2: begin expo = emax; frac = frac | (64'd1 << (fb - 1)); end
            3: begin expo = emax; frac = (frac & (fmask >> 1)) | 64'd1; end
            4: begin expo = 0; frac = (frac >> $urandom_range(0, fb - 1)) | 64'd1; end
            5: begin expo = emax - 1; frac = $urandom_range(0, 1) ? fmask : frac; end
            6: begin expo = 1; frac = $urandom_range(0, 1) ? 64'd0 : frac; end
            7: begin
                expo = 64'(bias + int'($urandom_range(0, 4)));
                frac = frac & ~(fmask >> 4);
            end
            8: val = {$urandom, $urandom};
            default: expo = 64'(bias + int'($urandom_range(0, 60)) - 30);
        endcase
        if (kind != 8) val = (sgn << (fb + eb)) | (expo << fb) | frac;
        if (!dp) val = {$urandom, val[31:0]};
        return val;
    endfunction

    // Offers one transaction and holds it until the unit takes it.
    task automatic offer(input logic [3:0] code, input logic dp, input logic [63:0] s1,
                         input logic [63:0] s2, input logic [63:0] d);
        i_valid                 <= 1'b1;
        i_data.req_type         <= code;
        i_data.double_precision <= dp;
        i_data.src_one          <= s1;
        i_data.src_two          <= s2;
        i_data.old_dest         <= d;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sent++;
        @(negedge i_clk);
    endtask

    task automatic idle_gap(input int n);
        i_valid <= 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    // Receiver: stretches of free flow, light and heavy stalling, plus one long hold-off
    // while the sender keeps pushing, so that the whole pipeline fills and backs up.
    initial begin
        int  run_len, mode;
        logic held;
        held    = 1'b0;
        i_stall = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (!held && sent >= HOLD_AT_ITEM) begin
                held = 1'b1;
                repeat (LONG_HOLD) begin
                    @(negedge i_clk);
                    i_stall <= 1'b1;
                end
            end
            run_len = $urandom_range(4, 40);
            mode    = $urandom_range(0, 3);
            repeat (run_len) begin
                @(negedge i_clk);
                case (mode)
                    0: i_stall <= 1'b0;
                    1: i_stall <= ($urandom_range(0, 99) < 25);
                    2: i_stall <= ($urandom_range(0, 99) < 70);
                    default: i_stall <= 1'($urandom_range(0, 1));
                endcase
            end
        end
    end

    initial begin
        int          burst;
        logic [3:0]  code;
        logic        dp;
        cycles  = 0;
        sent    = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data  = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Every variant on 2 * 3 and 1, then the unknown variants.
        for (int v = 0; v < 16; v++) offer(4'(v), 1'b1, D_TWO, D_THREE, D_ONE);
        // A signalling NaN comes back quieted.
        offer(VARIANT_231_ADD, 1'b1, D_ONE, D_SNAN, D_TWO);
        // Infinity times zero, and infinities of opposite sign, give the default NaN.
        offer(VARIANT_231_ADD, 1'b1, D_INF, 64'd0, D_ONE);
        offer(VARIANT_231_ADD, 1'b1, D_INF, D_ONE, D_NINF);
        // Negative zero product plus negative zero stays negative.
        offer(VARIANT_231_ADD, 1'b1, D_NZERO, D_ONE, D_NZERO);
        // Exact cancellation gives positive zero.
        offer(VARIANT_231_ADD, 1'b1, D_TWO, D_THREE, D_NSIX);
        // Overflow to infinity, and results in the subnormal range.
        offer(VARIANT_231_ADD, 1'b1, D_MAX, D_TWO, D_ONE);
        offer(VARIANT_231_ADD, 1'b1, D_TINY, D_HALF, D_TINY);
        // Binary32 with junk in the upper halves, including overflow and subnormals.
        offer(VARIANT_231_ADD, 1'b0, S_ONE, S_TWO, S_ONE);
        offer(VARIANT_231_ADD, 1'b0, S_MAX, S_MAX, S_TINY);
        offer(VARIANT_231_ADD, 1'b0, S_TINY, S_ONE, S_TINY);

        // Random transactions in bursts of random length, most of them followed by a random gap.
        while (sent < RANDOM_ITEMS + 26) begin
            burst = $urandom_range(1, 24);
            repeat (burst) begin
                code = ($urandom_range(0, 19) == 0)
                       ? 4'($urandom_range(FIRST_BAD_VARIANT, 15))
                       : 4'($urandom_range(0, LAST_GOOD_VARIANT));
                dp   = 1'($urandom_range(0, 1));
                offer(code, dp, pick_operand(dp), pick_operand(dp), pick_operand(dp));
            end
            if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 8));
            // At least once, the sender lets the pipeline drain completely before going on.
            if (sent >= PAUSE_AT_ITEM && sent < PAUSE_AT_ITEM + 25) begin
                i_valid <= 1'b0;
                while (outstanding != 0) @(negedge i_clk);
            end
        end
        i_valid <= 1'b0;

        while (outstanding != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
